>>> rtl/pnea_pkg.sv
// Shared types and constants for the pose normal-equation accumulator.
// No dependencies; imported by every other file in rtl/ except pnea_if.sv.
`timescale 1ns / 1ps

package pnea_pkg;

  localparam int ROW_FULL     = 6;
  localparam int ROW_KEPT     = 5;
  localparam int MAT_COUNT    = 25;
  localparam int RESULT_COUNT = 30;

  // configuration register indexes
  localparam logic [1:0] REG_POSE0 = 2'd0;
  localparam logic [1:0] REG_POSE1 = 2'd1;
  localparam logic [1:0] REG_POSE2 = 2'd2;
  localparam logic [1:0] REG_DROP  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_JAC,
    ST_ACC
  } top_state_t;

  typedef enum logic [1:0] {
    JS_IDLE,
    JS_PROD,
    JS_ROW
  } jac_state_t;

  typedef enum logic {
    AS_IDLE,
    AS_RUN
  } acc_state_t;

  typedef struct packed {
    logic signed [23:0] ref_u;
    logic signed [23:0] ref_v;
    logic signed [23:0] cur_u;
    logic signed [23:0] cur_v;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_z;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
  } point_t;

  typedef struct packed {
    logic                          done;
    logic [ROW_KEPT-1:0][31:0]     j5;
  } jac_result_t;

  typedef struct packed {
    logic               start;
    logic               last;
    logic signed [23:0] e_direct;
    logic signed [23:0] e_trans;
  } acc_ctl_t;

endpackage

>>> rtl/pnea_if.sv
// Valid/ready channel interfaces for input correspondences and result words.
// Depends on nothing; used by the top level and the accumulator unit.
`timescale 1ns / 1ps

interface pnea_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] point_weight;
  logic [47:0] ref_image_uv;
  logic [47:0] cur_image_uv;
  logic signed [31:0] ref_space_x;
  logic signed [31:0] ref_space_y;
  logic signed [31:0] ref_space_z;
  logic signed [31:0] cur_space_x;
  logic signed [31:0] cur_space_y;
  logic signed [31:0] cur_space_z;
  logic [47:0] residual_pair;
  logic        last_point;

  modport source (output valid, point_weight, ref_image_uv, cur_image_uv,
                  ref_space_x, ref_space_y, ref_space_z,
                  cur_space_x, cur_space_y, cur_space_z,
                  residual_pair, last_point,
                  input ready);
  modport sink (input valid, point_weight, ref_image_uv, cur_image_uv,
                ref_space_x, ref_space_y, ref_space_z,
                cur_space_x, cur_space_y, cur_space_z,
                residual_pair, last_point,
                output ready);
endinterface

interface pnea_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         entry_index;
  logic signed [63:0] entry_value;
  logic               last_entry;

  modport source (output valid, entry_index, entry_value, last_entry, input ready);
  modport sink (input valid, entry_index, entry_value, last_entry, output ready);
endinterface

>>> rtl/pose_normal_equation_accumulator_core.sv
// Top level: input capture, configuration registers, item sequencer.
// Depends on pnea_pkg, pnea_if, pnea_jacobian and pnea_accum.
`timescale 1ns / 1ps

// Pose normal-equation accumulator.
// in_ch carries one correspondence word (weight, 2D/3D point pairs, two
// residuals, last flag). For each word the block builds the five-entry
// Jacobian row and adds its outer product and gradient terms, for the
// direct and the transposed residual, into a 30-entry store of 64-bit
// saturating sums. A word with last_point set makes the block send all 30
// sums on out_ch (entry_index 0..29, last_entry on the final one) and clear
// the store in the same pass.
// One word at a time: 27 point-product steps plus 6 row-finishing steps
// in the Jacobian unit, then a read-modify-write of each of the 30 entries
// through the single accumulator memory. in_ch.ready is high only between
// words. Configuration (cfg_we/cfg_index/cfg_data) must be written only
// while the block is idle; the block does not enforce this.
// Reset (rst, synchronous) loads the identity pose, drops translation
// column 2 and marks every store entry invalid, so it reads as zero.
// A stalled receiver holds the result word; the flush pass waits on it.
module pose_normal_equation_accumulator_core
  import pnea_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pnea_in_if.sink     in_ch,
  pnea_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  top_state_t state, state_next;

  logic [63:0] pose0, pose1, pose2;
  logic [1:0]  drop_col;

  logic [15:0] weight_r;
  point_t      pt_r;
  logic [47:0] resid_r;
  logic        last_r;

  logic        accept, jac_start;
  jac_result_t jres;
  acc_ctl_t    actl;
  logic        acc_done;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      pose0    <= 64'h1000_0000_0000_0000;
      pose1    <= 64'h0000_1000_0000_0000;
      pose2    <= 64'h0000_0000_1000_0000;
      drop_col <= 2'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POSE0: pose0 <= cfg_data;
        REG_POSE1: pose1 <= cfg_data;
        REG_POSE2: pose2 <= cfg_data;
        REG_DROP:  drop_col <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_JAC;
      ST_JAC:  if (jres.done) state_next = ST_ACC;
      ST_ACC:  if (acc_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    accept      = in_ch.valid && (state == ST_IDLE);
    jac_start   = accept;
  end

  assign actl.start = (state == ST_JAC) && jres.done;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // capture the word
  always_ff @(posedge clk) begin
    if (accept) begin
      weight_r   <= in_ch.point_weight;
      pt_r.ref_u <= in_ch.ref_image_uv[47:24];
      pt_r.ref_v <= in_ch.ref_image_uv[23:0];
      pt_r.cur_u <= in_ch.cur_image_uv[47:24];
      pt_r.cur_v <= in_ch.cur_image_uv[23:0];
      pt_r.ref_x <= in_ch.ref_space_x;
      pt_r.ref_y <= in_ch.ref_space_y;
      pt_r.ref_z <= in_ch.ref_space_z;
      pt_r.cur_x <= in_ch.cur_space_x;
      pt_r.cur_y <= in_ch.cur_space_y;
      pt_r.cur_z <= in_ch.cur_space_z;
      resid_r    <= in_ch.residual_pair;
      last_r     <= in_ch.last_point;
    end
  end

  assign actl.last     = last_r;
  assign actl.e_direct = resid_r[47:24];
  assign actl.e_trans  = resid_r[23:0];

  // code 3 behaves as column 2
  logic [1:0] drop_eff;
  assign drop_eff = (drop_col == 2'd3) ? 2'd2 : drop_col;

  pnea_jacobian u_jac (
    .clk    (clk),
    .rst    (rst),
    .start  (jac_start),
    .weight (weight_r),
    .pt     (pt_r),
    .pose0  (pose0),
    .pose1  (pose1),
    .pose2  (pose2),
    .drop   (drop_eff),
    .res    (jres)
  );

  pnea_accum u_acc (
    .clk    (clk),
    .rst    (rst),
    .ctl    (actl),
    .j5     (jres.j5),
    .done   (acc_done),
    .out_ch (out_ch)
  );

endmodule

>>> rtl/pnea_jacobian.sv
// Jacobian row unit: 27 point-product steps with six MACs, then five
// weighted, negated, saturated row entries. Depends on pnea_pkg.
`timescale 1ns / 1ps

module pnea_jacobian
  import pnea_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] weight,
  input  point_t      pt,
  input  logic [63:0] pose0,
  input  logic [63:0] pose1,
  input  logic [63:0] pose2,
  input  logic [1:0]  drop,
  output jac_result_t res
);

  jac_state_t state, state_next;

  logic [1:0] term, ia, ib;
  logic signed [40:0] pq_q;
  logic signed [20:0] tab_q [ROW_FULL];
  logic signed [63:0] acc_s [ROW_FULL];
  logic               mac_v;
  logic [2:0]         col;
  logic [41:0]        m_lo;
  logic [37:0]        m_hi;
  logic               b_v;
  logic [ROW_KEPT-1:0][31:0] j5_sh;

  logic step_go, a_go, finish, last_step;

  function automatic logic signed [15:0] pose_field(input logic [63:0] row,
                                                    input logic [1:0] idx);
    logic signed [15:0] f;
    unique case (idx)
      2'd0: f = row[63:48];
      2'd1: f = row[47:32];
      2'd2: f = row[31:16];
      default: f = row[15:0];
    endcase
    return f;
  endfunction

  // entry (b, m) of -[c]x
  function automatic logic signed [20:0] neg_skew(input logic signed [15:0] c0,
                                                  input logic signed [15:0] c1,
                                                  input logic signed [15:0] c2,
                                                  input logic [1:0] b,
                                                  input logic [1:0] m);
    logic signed [20:0] v;
    v = '0;
    unique case (b)
      2'd0: begin
        if (m == 2'd1) v = 21'(c2);
        else if (m == 2'd2) v = -21'(c1);
      end
      2'd1: begin
        if (m == 2'd2) v = 21'(c0);
        else if (m == 2'd0) v = -21'(c2);
      end
      default: begin
        if (m == 2'd0) v = 21'(c1);
        else if (m == 2'd1) v = -21'(c0);
      end
    endcase
    return v;
  endfunction

  // ---- operand selection for one point product
  logic signed [31:0] p_op, q_op, ref_img, cur_img, ref_sp, cur_sp;
  logic signed [63:0] pq_full;
  logic signed [40:0] pq_next;

  always_comb begin
    unique case (ia)
      2'd0: ref_img = 32'(pt.ref_u);
      2'd1: ref_img = 32'(pt.ref_v);
      default: ref_img = 32'sd65536;
    endcase
    unique case (ia)
      2'd0: ref_sp = pt.ref_x;
      2'd1: ref_sp = pt.ref_y;
      default: ref_sp = pt.ref_z;
    endcase
    unique case (ib)
      2'd0: cur_img = 32'(pt.cur_u);
      2'd1: cur_img = 32'(pt.cur_v);
      default: cur_img = 32'sd65536;
    endcase
    unique case (ib)
      2'd0: cur_sp = pt.cur_x;
      2'd1: cur_sp = pt.cur_y;
      default: cur_sp = pt.cur_z;
    endcase
    p_op = (term == 2'd1) ? ref_sp : ref_img;
    q_op = (term == 2'd0) ? cur_sp : cur_img;
    pq_full = p_op * q_op;
    pq_next = 41'((pq_full + 64'sd32768) >>> 16);
  end

  // ---- table row for the current (a, b)
  logic signed [15:0] cv [3];
  logic signed [15:0] tv [3];
  logic signed [20:0] tab_next [ROW_FULL];

  always_comb begin
    logic signed [32:0] diff;
    cv[0] = pose_field(pose0, ia);
    cv[1] = pose_field(pose1, ia);
    cv[2] = pose_field(pose2, ia);
    tv[0] = pose_field(pose0, 2'd3);
    tv[1] = pose_field(pose1, 2'd3);
    tv[2] = pose_field(pose2, 2'd3);
    for (int k = 0; k < 3; k++) begin
      diff = 33'(tv[ib] * cv[k]) - 33'(tv[k] * cv[ib]);
      if (term == 2'd2) begin
        tab_next[k]     = neg_skew(cv[0], cv[1], cv[2], ib, 2'(k));
        tab_next[k + 3] = 21'((diff + 33'sd2048) >>> 12);
      end else begin
        tab_next[k]     = '0;
        tab_next[k + 3] = neg_skew(cv[0], cv[1], cv[2], ib, 2'(k));
      end
    end
  end

  // ---- FSM
  assign last_step = (term == 2'd2) && (ia == 2'd2) && (ib == 2'd2);

  always_comb begin
    state_next = state;
    unique case (state)
      JS_IDLE: if (start) state_next = JS_PROD;
      JS_PROD: if (last_step) state_next = JS_ROW;
      JS_ROW:  if (finish) state_next = JS_IDLE;
      default: state_next = JS_IDLE;
    endcase
  end

  always_comb begin
    step_go = (state == JS_PROD);
    a_go    = (state == JS_ROW) && !mac_v && (col < 3'(ROW_FULL));
    finish  = (state == JS_ROW) && !mac_v && (col == 3'(ROW_FULL)) && !b_v;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= JS_IDLE;
    else state <= state_next;
  end

  // ---- product step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      term  <= '0;
      ia    <= '0;
      ib    <= '0;
      mac_v <= 1'b0;
    end else begin
      mac_v <= step_go;
      if (start) begin
        term <= '0;
        ia   <= '0;
        ib   <= '0;
      end else if (step_go) begin
        if (ib == 2'd2) begin
          ib <= '0;
          if (ia == 2'd2) begin
            ia   <= '0;
            term <= term + 2'd1;
          end else begin
            ia <= ia + 2'd1;
          end
        end else begin
          ib <= ib + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      pq_q <= pq_next;
      for (int k = 0; k < ROW_FULL; k++) tab_q[k] <= tab_next[k];
    end
  end

  // six MACs, wrapping 64-bit sums
  always_ff @(posedge clk) begin
    for (int k = 0; k < ROW_FULL; k++) begin
      if (start) acc_s[k] <= '0;
      else if (mac_v) acc_s[k] <= acc_s[k] + 64'(pq_q * tab_q[k]);
    end
  end

  // ---- row finishing: round, weight, negate, saturate
  logic signed [63:0] s_sel, x_r;

  always_comb begin
    unique case (col)
      3'd0: s_sel = acc_s[0];
      3'd1: s_sel = acc_s[1];
      3'd2: s_sel = acc_s[2];
      3'd3: s_sel = acc_s[3];
      3'd4: s_sel = acc_s[4];
      3'd5: s_sel = acc_s[5];
      default: s_sel = '0;
    endcase
    x_r = (s_sel + 64'sd2048) >>> 12;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      b_v <= 1'b0;
    end else begin
      if (start) col <= '0;
      else if (a_go) col <= col + 3'd1;
      b_v <= a_go && (col != {1'b0, drop});
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      m_lo <= x_r[25:0] * weight;
      m_hi <= 38'(x_r[63:26] * weight);
    end
  end

  logic [63:0]        wprod, rnd;
  logic signed [63:0] jv;
  logic signed [31:0] jsat;

  always_comb begin
    wprod = {m_hi, 26'b0} + {22'b0, m_lo};
    rnd   = (~wprod + 64'd1) + 64'd16384;
    jv    = $signed(rnd) >>> 15;
    if (jv > 64'sd2147483647) jsat = 32'sh7FFFFFFF;
    else if (jv < -64'sd2147483648) jsat = 32'sh80000000;
    else jsat = jv[31:0];
  end

  always_ff @(posedge clk) begin
    if (b_v) begin
      for (int i = 0; i < ROW_KEPT - 1; i++) j5_sh[i] <= j5_sh[i + 1];
      j5_sh[ROW_KEPT-1] <= jsat;
    end
  end

  assign res.done = finish;
  assign res.j5   = j5_sh;

endmodule

>>> rtl/pnea_accum.sv
// Accumulator store: 30-entry synchronous memory with read-modify-write,
// valid bits for reset, and the result word register. Depends on pnea_pkg.
`timescale 1ns / 1ps

module pnea_accum
  import pnea_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  acc_ctl_t                   ctl,
  input  logic [ROW_KEPT-1:0][31:0]  j5,
  output logic                       done,
  pnea_out_if.source                 out_ch
);

  acc_state_t state, state_next;

  logic [63:0] mem [RESULT_COUNT];
  logic [RESULT_COUNT-1:0] vld;
  logic [63:0] rdata;
  logic        rvld;

  logic [4:0] n, p_idx;
  logic [2:0] l_cnt;
  logic       p_v;
  logic signed [63:0] p1, p2;
  logic [ROW_KEPT-1:0][31:0] ring_a, ring_b;

  logic               out_v, out_last;
  logic [4:0]         out_idx;
  logic signed [63:0] out_val;

  logic issue, stall, wb;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
    return s[63:0];
  endfunction

  always_comb begin
    state_next = state;
    unique case (state)
      AS_IDLE: if (ctl.start) state_next = AS_RUN;
      AS_RUN:  if (n == 5'(RESULT_COUNT) && !p_v) state_next = AS_IDLE;
      default: state_next = AS_IDLE;
    endcase
  end

  always_comb begin
    stall = p_v && ctl.last && out_v && !out_ch.ready;
    issue = (state == AS_RUN) && !stall && (n < 5'(RESULT_COUNT));
    wb    = p_v && !stall;
    done  = (state == AS_RUN) && (n == 5'(RESULT_COUNT)) && !p_v;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= AS_IDLE;
    else state <= state_next;
  end

  // operand rings: a steps every entry, b every row of five
  logic               grad;
  logic signed [31:0] op1, op2;

  always_comb begin
    grad = (n >= 5'(MAT_COUNT));
    op1  = grad ? 32'(ctl.e_direct) : $signed(ring_b[0]);
    op2  = grad ? 32'(ctl.e_trans)  : $signed(ring_b[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n     <= '0;
      l_cnt <= '0;
      p_v   <= 1'b0;
    end else if (ctl.start) begin
      n      <= '0;
      l_cnt  <= '0;
      p_v    <= 1'b0;
    end else if (!stall) begin
      p_v <= issue;
      if (issue) begin
        n     <= n + 5'd1;
        l_cnt <= (l_cnt == 3'(ROW_KEPT - 1)) ? 3'd0 : l_cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      ring_a <= j5;
      ring_b <= j5;
    end else if (issue) begin
      p_idx  <= n;
      p1     <= $signed(ring_a[0]) * op1;
      p2     <= $signed(ring_a[0]) * op2;
      ring_a <= {ring_a[0], ring_a[ROW_KEPT-1:1]};
      if (l_cnt == 3'(ROW_KEPT - 1)) ring_b <= {ring_b[0], ring_b[ROW_KEPT-1:1]};
    end
  end

  // memory: one read, one write per cycle while not stalled
  logic signed [63:0] cur, sum;
  always_comb begin
    cur = rvld ? $signed(rdata) : 64'sd0;
    sum = sat_add(sat_add(cur, p1), p2);
  end

  always_ff @(posedge clk) begin
    if (issue) rdata <= mem[n];
    if (wb) mem[p_idx] <= ctl.last ? 64'd0 : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      if (issue) rvld <= vld[n];
      if (wb) vld[p_idx] <= 1'b1;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (wb && ctl.last) out_v <= 1'b1;
    else if (out_ch.ready) out_v <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (wb && ctl.last) begin
      out_idx  <= p_idx;
      out_val  <= sum;
      out_last <= (p_idx == 5'(RESULT_COUNT - 1));
    end
  end

  assign out_ch.valid       = out_v;
  assign out_ch.entry_index = out_idx;
  assign out_ch.entry_value = out_val;
  assign out_ch.last_entry  = out_last;

endmodule

>>> tb/sv/pnea_tb_if.sv
// Testbench-side copies of nothing: the channel interfaces come from rtl/pnea_if.sv.
// This file holds the testbench result record type; depends on nothing.
`timescale 1ns / 1ps

package pnea_tb_pkg;
  typedef struct {
    logic [4:0]         index;
    logic signed [63:0] value;
    logic               last;
  } sum_word_t;
endpackage

>>> tb/sv/tb_top.sv
// Testbench for pose_normal_equation_accumulator_core: directed and random
// correspondence words, bit-exact prediction of the 30 sums, scoreboard checks.
// Depends on pnea_pkg, pnea_if (rtl) and pnea_tb_pkg.
`timescale 1ns / 1ps

module tb_top;
  import pnea_pkg::*;
  import pnea_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_POSE0;
  logic [63:0] cfg_data = '0;

  always #5 clk = ~clk;

  pnea_in_if  in_ch();
  pnea_out_if out_ch();

  pose_normal_equation_accumulator_core uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  int errors = 0;
  longint unsigned cycles = 0;
  bit quiet_tail = 0;  // no idling in the last part of the run

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor: own copy of configuration and 30-entry sum store
  // ---------------------------------------------------------------------------
  logic [63:0] pose_q[3];
  logic [1:0]  drop_col;
  longint      mat_sum[25];
  longint      grad_sum[5];

  function automatic longint sx(input logic [63:0] v, input int w);
    logic [63:0] r;
    r = v << (64 - w);
    return $signed(r) >>> (64 - w);
  endfunction

  // round half up then arithmetic shift (floor)
  function automatic longint rnd(input longint x, input int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint sadd(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a >= 0 && b > 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
    return s;
  endfunction

  // entry (b,m) of the negated cross-product matrix of c
  function automatic longint nskew(input longint c[3], input int b, input int m);
    if (m == (b + 1) % 3) return c[(b + 2) % 3];
    if (m == (b + 2) % 3) return -c[(b + 1) % 3];
    return 0;
  endfunction

  typedef longint tab_t[9][6];

  function automatic void point_term(inout longint s[6], input longint p[3],
                                     input longint q[3], input tab_t tb);
    longint pq;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) begin
        pq = rnd(p[a] * q[b], 16);
        for (int k = 0; k < 6; k++) s[k] += pq * tb[3*a+b][k];
      end
  endfunction

  function automatic void add_sums(input longint j5[5], input longint e);
    for (int k = 0; k < 5; k++) begin
      for (int l = 0; l < 5; l++) mat_sum[k*5+l] = sadd(mat_sum[k*5+l], j5[k] * j5[l]);
      grad_sum[k] = sadd(grad_sum[k], j5[k] * e);
    end
  endfunction

  typedef struct {
    logic [15:0] w;
    logic [47:0] ruv, cuv, res;
    logic [31:0] rx, ry, rz, cx, cy, cz;
    logic        last;
  } corr_t;

  // accumulate one correspondence; on a last word push the 30 expected sums
  function automatic void accumulate_point(input corr_t c, ref sum_word_t exp_q[$]);
    longint rot[3][3], t[3], col[3];
    tab_t tr, te;
    longint ar[3], ac[3], br[3], bc[3], s[6], j5[5], v;
    int drop, pos;
    sum_word_t wd;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) rot[i][k] = sx(pose_q[i] >> (48 - 16*k), 16);
      t[i] = sx(pose_q[i], 16);
    end
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < 3; i++) col[i] = rot[i][a];
      for (int b = 0; b < 3; b++)
        for (int k = 0; k < 3; k++) begin
          tr[3*a+b][k] = 0;
          tr[3*a+b][k+3] = nskew(col, b, k);
          te[3*a+b][k] = nskew(col, b, k);
          te[3*a+b][k+3] = rnd(t[b] * col[k] - t[k] * col[b], 12);
        end
    end
    ar[0] = sx(c.ruv >> 24, 24); ar[1] = sx(c.ruv, 24); ar[2] = 65536;
    ac[0] = sx(c.cuv >> 24, 24); ac[1] = sx(c.cuv, 24); ac[2] = 65536;
    br[0] = sx(c.rx, 32); br[1] = sx(c.ry, 32); br[2] = sx(c.rz, 32);
    bc[0] = sx(c.cx, 32); bc[1] = sx(c.cy, 32); bc[2] = sx(c.cz, 32);
    for (int k = 0; k < 6; k++) s[k] = 0;
    point_term(s, ar, bc, tr);
    point_term(s, br, ac, tr);
    point_term(s, ar, ac, te);
    drop = (drop_col > 2) ? 2 : int'(drop_col);  // value 3 behaves as 2
    pos = 0;
    for (int k = 0; k < 6; k++) begin
      if (k == drop) continue;
      v = rnd(-(rnd(s[k], 12) * longint'(c.w)), 15);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      j5[pos++] = v;
    end
    add_sums(j5, sx(c.res >> 24, 24));
    add_sums(j5, sx(c.res, 24));
    if (c.last) begin
      for (int k = 0; k < 30; k++) begin
        wd.index = k[4:0];
        wd.value = (k < 25) ? mat_sum[k] : grad_sum[k-25];
        wd.last  = (k == 29);
        exp_q.push_back(wd);
      end
      foreach (mat_sum[i]) mat_sum[i] = 0;
      foreach (grad_sum[i]) grad_sum[i] = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------
  class sum_scoreboard;
    sum_word_t pending_sums[$];
    function void note_point(corr_t c);
      accumulate_point(c, pending_sums);
    endfunction
    task check_word(sum_word_t got);
      sum_word_t e;
      if (pending_sums.size() == 0) begin
        report($sformatf("unexpected word index %0d", got.index));
        return;
      end
      e = pending_sums.pop_front();
      if (got.index !== e.index)
        report($sformatf("index got %0d exp %0d", got.index, e.index));
      if (got.value !== e.value)
        report($sformatf("entry %0d value got %0d exp %0d", e.index, got.value, e.value));
      if (got.last !== e.last)
        report($sformatf("entry %0d last got %0b exp %0b", e.index, got.last, e.last));
    endtask
  endclass

  sum_scoreboard sb = new();

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid = 0; in_ch.point_weight = 0; in_ch.ref_image_uv = 0;
    in_ch.cur_image_uv = 0; in_ch.ref_space_x = 0; in_ch.ref_space_y = 0;
    in_ch.ref_space_z = 0; in_ch.cur_space_x = 0; in_ch.cur_space_y = 0;
    in_ch.cur_space_z = 0; in_ch.residual_pair = 0; in_ch.last_point = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // receiver: random stall bursts, sampling at the edge
  initial begin
    int stall;
    sum_word_t got;
    @(posedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 10);
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got.index = out_ch.entry_index;
        got.value = out_ch.entry_value;
        got.last  = out_ch.last_entry;
        sb.check_word(got);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_POSE0) pose_q[0] = val;
    else if (idx == REG_POSE1) pose_q[1] = val;
    else if (idx == REG_POSE2) pose_q[2] = val;
    else drop_col = val[1:0];
    @(posedge clk);
  endtask

  task automatic send_point(input corr_t c);
    if (!quiet_tail && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 10)) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.point_weight <= c.w; in_ch.ref_image_uv <= c.ruv; in_ch.cur_image_uv <= c.cuv;
    in_ch.ref_space_x <= c.rx; in_ch.ref_space_y <= c.ry; in_ch.ref_space_z <= c.rz;
    in_ch.cur_space_x <= c.cx; in_ch.cur_space_y <= c.cy; in_ch.cur_space_z <= c.cz;
    in_ch.residual_pair <= c.res; in_ch.last_point <= c.last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_point(c);
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for the store to drain; the block may still be busy on a non-last word
  task automatic wait_drained();
    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [47:0] rnd_uv(input bit full);
    logic [23:0] u, v;
    u = full ? 24'($urandom) : 24'(int'($urandom_range(0, 4000000)) - 2000000);
    v = full ? 24'($urandom) : 24'(int'($urandom_range(0, 4000000)) - 2000000);
    return {u, v};
  endfunction

  function automatic logic [31:0] rnd_pt(input bit full);
    return full ? $urandom : 32'(int'($urandom_range(0, 8000000)) - 4000000);
  endfunction

  function automatic corr_t rnd_point(input bit full, input bit last);
    corr_t c;
    c.w = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    c.ruv = rnd_uv(full); c.cuv = rnd_uv(full);
    c.rx = rnd_pt(full); c.ry = rnd_pt(full); c.rz = rnd_pt(full);
    c.cx = rnd_pt(full); c.cy = rnd_pt(full); c.cz = rnd_pt(full);
    c.res = {24'($urandom), 24'($urandom)};
    c.last = last;
    return c;
  endfunction

  function automatic logic [63:0] rnd_pose(input bit full);
    logic [63:0] p;
    p = {$urandom, $urandom};
    if (!full)
      for (int i = 0; i < 4; i++) p[16*i +: 16] = 16'(int'($urandom_range(0, 8192)) - 4096);
    return p;
  endfunction

  initial begin
    corr_t c;
    logic [63:0] ext_cfg[3];
    pose_q[0] = 64'd1152921504606846976; pose_q[1] = 64'd17592186044416;
    pose_q[2] = 64'd268435456; drop_col = 2;
    foreach (mat_sum[i]) mat_sum[i] = 0;
    foreach (grad_sum[i]) grad_sum[i] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset pose, extremes of every field, weights 0, 1.0, max
    c = rnd_point(0, 1); c.w = 16'd32768; send_point(c);
    c.w = 16'd0; c.ruv = '0; c.cuv = '0; c.res = '0; c.last = 1'b1;
    c.rx = 0; c.ry = 0; c.rz = 0; c.cx = 0; c.cy = 0; c.cz = 0; send_point(c);
    c.w = 16'hFFFF; c.ruv = '1; c.cuv = {24'h7FFFFF, 24'h800000};
    c.rx = 32'h7FFFFFFF; c.ry = 32'h80000000; c.rz = 32'h7FFFFFFF;
    c.cx = 32'h80000000; c.cy = 32'h7FFFFFFF; c.cz = 32'h80000000;
    c.res = {24'h7FFFFF, 24'h800000}; c.last = 1'b0; send_point(c);
    c.ruv = {24'h800000, 24'h7FFFFF}; c.cuv = '1; c.res = {24'h800000, 24'h7FFFFF};
    c.rx = 32'h80000000; c.ry = 32'h7FFFFFFF; c.cx = 32'h7FFFFFFF; c.last = 1'b0;
    send_point(c);
    // saturation: many extreme words in one batch
    repeat (6) send_point(c);
    c.last = 1'b1; send_point(c);
    wait_drained();

    // every dropped column, including 3 acting as 2, with extreme poses for codes 1 and 3
    ext_cfg[0] = 64'h7FFF_8000_7FFF_8000;
    ext_cfg[1] = 64'h8000_7FFF_8000_7FFF;
    ext_cfg[2] = 64'hFFFF_FFFF_FFFF_FFFF;
    for (int d = 0; d < 4; d++) begin
      write_reg(REG_DROP, 2'(d));
      for (int r = 0; r < 3; r++)
        write_reg(r == 0 ? REG_POSE0 : r == 1 ? REG_POSE1 : REG_POSE2,
                  d[0] ? ext_cfg[r] : rnd_pose(0));
      send_point(rnd_point(1, 0));
      send_point(rnd_point(0, 1));
      wait_drained();
    end
    write_reg(REG_POSE0, 64'h0); write_reg(REG_POSE1, 64'h0); write_reg(REG_POSE2, 64'h0);
    send_point(rnd_point(0, 1));
    wait_drained();

    // random batches, new settings between phases
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_POSE0, rnd_pose(ph == 5));
      write_reg(REG_POSE1, rnd_pose(ph == 5));
      write_reg(REG_POSE2, rnd_pose(ph == 5));
      write_reg(REG_DROP, 2'($urandom));
      if (ph == 5) quiet_tail = 1;
      for (int n = 0; n < 38; n++) begin
        c = rnd_point($urandom_range(0, 4) == 0, $urandom_range(0, 3) == 0 || n == 37);
        send_point(c);
        // pause the sender until all sums have come back
        if (ph == 2 && n == 20) while (sb.pending_sums.size() != 0) @(posedge clk);
      end
      wait_drained();
    end

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // worst case per word: block processing time, sender gaps, receiver stalls on the 30 result words
  always @(posedge clk)
    if (cycles > 400000) begin
      $display("simulation failed");
      $finish;
    end

endmodule

>>> sim.f
rtl/pnea_pkg.sv
rtl/pnea_if.sv
rtl/pnea_jacobian.sv
rtl/pnea_accum.sv
rtl/pose_normal_equation_accumulator_core.sv
tb/sv/pnea_tb_if.sv
tb/sv/tb_top.sv
